// ----- src/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int MAX_CHARS = 4;
	localparam int IDX_W     = $clog2(MAX_CHARS);

	localparam logic [6:0] PAD_CHAR = 7'h3D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_word_t;

	typedef struct packed {
		logic [6:0] ascii_char;
		logic       run_last;
		logic       message_end;
	} out_word_t;

	// Characters caused by one input byte, ready to be shifted out.
	typedef struct packed {
		logic [MAX_CHARS-1:0][6:0] chars;
		logic [IDX_W-1:0]          last_idx;
		logic                      fin;
	} job_t;

	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		logic [6:0] c;
		if (v < 6'd26) begin
			c = 7'h41 + {1'b0, v};
		end else if (v < 6'd52) begin
			c = 7'h61 + {1'b0, v} - 7'd26;
		end else if (v < 6'd62) begin
			c = 7'h30 + {1'b0, v} - 7'd52;
		end else if (v == 6'd62) begin
			c = 7'h2B;
		end else begin
			c = 7'h2F;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- src/b64e_front.sv -----
// ----------------------------------------------------------------------------
// b64e_front
// Tracks the three-byte group and builds the character set for each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire b64e_pkg::in_word_t word,
	output b64e_pkg::job_t        job
);
	import b64e_pkg::*;

	logic [1:0] pos_q;
	logic [3:0] left_q;
	logic [1:0] pos_nx;
	logic [3:0] left_nx;
	logic [7:0] b;

	assign b = word.data_byte;

	always_comb begin
		job.chars    = {MAX_CHARS{PAD_CHAR}};
		job.last_idx = '0;
		job.fin      = word.final_byte;
		pos_nx       = 2'd0;
		left_nx      = 4'd0;
		unique case (pos_q)
			2'd1: begin
				job.chars[0] = sextet_char({left_q[1:0], b[7:4]});
				left_nx      = b[3:0];
				pos_nx       = 2'd2;
			end
			2'd2: begin
				job.chars[0] = sextet_char({left_q, b[7:6]});
				job.chars[1] = sextet_char(b[5:0]);
				job.last_idx = IDX_W'(1);
			end
			default: begin
				// position 3 never arises; treat as start of group
				job.chars[0] = sextet_char(b[7:2]);
				left_nx      = {2'b00, b[1:0]};
				pos_nx       = 2'd1;
			end
		endcase
		if (word.final_byte) begin
			// flush the partial sextet and pad to a multiple of four
			if (pos_nx == 2'd1) begin
				job.chars[1] = sextet_char({left_nx[1:0], 4'b0000});
				job.last_idx = IDX_W'(3);
			end else if (pos_nx == 2'd2) begin
				job.chars[1] = sextet_char({left_nx, 2'b00});
				job.last_idx = IDX_W'(2);
			end
			pos_nx  = 2'd0;
			left_nx = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 2'd0;
			left_q <= 4'd0;
		end else if (take) begin
			pos_q  <= pos_nx;
			left_q <= left_nx;
		end
	end

endmodule

`default_nettype wire

// ----- src/b64e_queue.sv -----
// ----------------------------------------------------------------------------
// b64e_queue
// Short FIFO of character jobs between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire b64e_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                avail,
	output b64e_pkg::job_t      head
);
	import b64e_pkg::*;

	job_t              entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign avail = (cnt_q != '0);
	assign head  = entries_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/b64e_back.sv -----
// ----------------------------------------------------------------------------
// b64e_back
// Serializes each job into output words, one character per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           avail,
	input  wire b64e_pkg::job_t head,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output b64e_pkg::out_word_t out_word
);
	import b64e_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	out_word_t        word_q;
	logic             load;
	logic             last;

	assign load      = avail && (!valid_q || out_ready);
	assign last      = (idx_q == head.last_idx);
	assign pop       = load && last;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q.ascii_char  <= head.chars[idx_q];
			word_q.run_last    <= last;
			word_q.message_end <= last && head.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			// advance through the job, rewind on its last character
			if (load) begin
				idx_q <= last ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/base64_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Byte-in, character-out base64 encoder with '=' padding on the final byte.
// ----------------------------------------------------------------------------
// Two register stages, the job queue and the output register; with the back end
// idle the first character of a byte passes through both after it is accepted.
// One character per cycle at the output register while out_ready is high; a byte
// yields 1 to 4 characters (1 or 2 mid-message, 2 to 4 on the final byte).
// A two-entry job queue lets bytes enter while earlier characters drain.
// Reset clears the group position, leftover bits, queue and output valid.
`default_nettype none

module base64_stream_encoder (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire b64e_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output b64e_pkg::out_word_t      out_word
);
	import b64e_pkg::*;

	job_t job;
	job_t head;
	logic take;
	logic full;
	logic avail;
	logic pop;

	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	b64e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.word   (in_word),
		.job    (job)
	);

	b64e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.push_job (job),
		.full     (full),
		.pop      (pop),
		.avail    (avail),
		.head     (head)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (avail),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64_stream_encoder: fixed and random messages go
// in over valid/ready, a local encoder predicts every character, run marker
// and message marker, and a monitor compares each output word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	import b64e_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int PHASE_BYTES = 90;
	localparam logic [511:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef enum logic [1:0] {
		GRP_FIRST  = 2'd0,
		GRP_SECOND = 2'd1,
		GRP_THIRD  = 2'd2
	} grp_pos_e;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_word;

	in_word_t  tx_bytes[$];
	out_word_t expected_chars[$];
	grp_pos_e  group_pos = GRP_FIRST;
	logic [3:0] carry_bits = 4'd0;
	logic      in_fire = 1'b0;
	logic      hold_off = 1'b0;
	int        gap_pct = 0;
	int        stall_pct = 0;
	int        error_count = 0;
	int        cycle_count = 0;

	base64_stream_encoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [6:0] b64_symbol(input logic [5:0] sextet);
		int unsigned pos;
		pos = 63 - sextet;
		return B64_ALPHABET[pos*8 +: 7];
	endfunction

	// Predict the characters one accepted byte releases and advance the group.
	task automatic encode_byte(input in_word_t w);
		logic [6:0] chars[0:3];
		int         n;
		out_word_t  ow;
		n = 0;
		case (group_pos)
			GRP_SECOND: begin
				chars[0] = b64_symbol({carry_bits[1:0], w.data_byte[7:4]});
				carry_bits = w.data_byte[3:0];
				group_pos = GRP_THIRD;
				n = 1;
			end
			GRP_THIRD: begin
				chars[0] = b64_symbol({carry_bits, w.data_byte[7:6]});
				chars[1] = b64_symbol(w.data_byte[5:0]);
				carry_bits = 4'd0;
				group_pos = GRP_FIRST;
				n = 2;
			end
			default: begin
				chars[0] = b64_symbol(w.data_byte[7:2]);
				carry_bits = {2'b00, w.data_byte[1:0]};
				group_pos = GRP_SECOND;
				n = 1;
			end
		endcase
		if (w.final_byte) begin
			// flush the partial sextet, then pad to a multiple of four
			if (group_pos == GRP_SECOND) begin
				chars[n] = b64_symbol({carry_bits[1:0], 4'b0000});
				chars[n+1] = PAD_CHAR;
				chars[n+2] = PAD_CHAR;
				n = n + 3;
			end else if (group_pos == GRP_THIRD) begin
				chars[n] = b64_symbol({carry_bits, 2'b00});
				chars[n+1] = PAD_CHAR;
				n = n + 2;
			end
			carry_bits = 4'd0;
			group_pos = GRP_FIRST;
		end
		for (int k = 0; k < n; k++) begin
			ow.ascii_char = chars[k];
			ow.run_last = (k == n - 1);
			ow.message_end = (k == n - 1) && w.final_byte;
			expected_chars.push_back(ow);
		end
	endtask

	task automatic check_char(input out_word_t got);
		out_word_t want;
		if (expected_chars.size() == 0) begin
			$error("unexpected word: ascii_char %h run_last %b message_end %b",
				got.ascii_char, got.run_last, got.message_end);
			error_count++;
		end else begin
			want = expected_chars.pop_front();
			if (got.ascii_char !== want.ascii_char) begin
				$error("ascii_char: expected %h, got %h", want.ascii_char, got.ascii_char);
				error_count++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %b, got %b", want.run_last, got.run_last);
				error_count++;
			end
			if (got.message_end !== want.message_end) begin
				$error("message_end: expected %b, got %b",
					want.message_end, got.message_end);
				error_count++;
			end
		end
	endtask

	// Bytes are right-aligned in msg, first byte of the message highest.
	task automatic send_fixed(input int len, input logic [39:0] msg);
		in_word_t w;
		for (int i = 0; i < len; i++) begin
			w.data_byte = msg[8*(len-1-i) +: 8];
			w.final_byte = (i == len - 1);
			tx_bytes.push_back(w);
		end
	endtask

	task automatic send_random(input int count);
		in_word_t w;
		int       len;
		int       sent;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
			for (int i = 0; i < len; i++) begin
				w.data_byte = $urandom_range(255);
				w.final_byte = (i == len - 1);
				tx_bytes.push_back(w);
			end
			sent = sent + len;
		end
	endtask

	task automatic drain;
		while (tx_bytes.size() != 0 || in_valid || expected_chars.size() != 0)
			@(posedge clk);
	endtask

	// Sample both handshakes at the rising edge.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			in_fire <= in_valid && in_ready;
			if (in_valid && in_ready)
				encode_byte(in_word);
			if (out_valid && out_ready)
				check_char(out_word);
		end
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Driver: advance to the next word only once the current one was taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (tx_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
					in_valid <= 1'b1;
					in_word <= tx_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// no idling: edge bytes, each group position ending a message
		send_fixed(1, 40'h00);
		send_fixed(1, 40'hFF);
		send_fixed(2, 40'h00FF);
		send_fixed(2, 40'hFF00);
		send_fixed(3, 40'h000000);
		send_fixed(3, 40'hFFFFFF);
		send_fixed(3, 40'hFBEFBE);
		send_fixed(3, 40'h4D616E);
		send_fixed(5, 40'h48656C6C6F);
		send_random(PHASE_BYTES);
		// hold the output back so the job queue fills and input stalls
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		hold_off = 1'b0;
		drain();

		gap_pct = 83;
		stall_pct = 0;
		send_random(PHASE_BYTES);
		drain();

		gap_pct = 0;
		stall_pct = 83;
		send_random(PHASE_BYTES);
		drain();

		gap_pct = 13;
		stall_pct = 13;
		send_random(PHASE_BYTES);
		drain();

		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
